### hw/rtl/irclfp_pkg.sv
// Package for the chat line field parser: character codes, phase and kind enums,
// and the result and queue entry types shared by the front, queue and back modules.
// No dependencies.
package irclfp_pkg;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_AT    = 8'h40;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam int unsigned MAX_PARAMS = 16;
  localparam int unsigned PCNT_TOP   = (MAX_PARAMS - 1 > 15) ? 15 : MAX_PARAMS - 1;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    PH_LINE_FIRST  = 4'd0,
    PH_TAGS        = 4'd1,
    PH_PFX_OR_CMD  = 4'd2,
    PH_PREFIX      = 4'd3,
    PH_CMD_FIRST   = 4'd4,
    PH_CMD         = 4'd5,
    PH_PARAM_FIRST = 4'd6,
    PH_PARAM       = 4'd7,
    PH_TRAILER     = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    KIND_TAGS    = 3'd0,
    KIND_PREFIX  = 3'd1,
    KIND_COMMAND = 3'd2,
    KIND_PARAM   = 3'd3,
    KIND_TRAILER = 3'd4,
    KIND_SEP     = 3'd5,
    KIND_EOL     = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [3:0]  pidx;
    logic        start;
    logic        cvalid;
    logic        last;
  } res_t;

  // one input byte's results: r0 always, r1 only when two is set
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

endpackage

### hw/rtl/irc_line_field_parser.sv
// Channel  | dir | tdata                                        | tuser      | tlast
// s_axis   | in  | [7:0] data_byte                              | -          | -
// m_axis   | out | [7:0] byte_value [11:8] param_index          | byte_kind  | last
//          |     | [12] param_start [13] command_valid          |            |
// One byte is accepted per cycle while the entry queue has room; results leave one per
// cycle while the receiver is ready, passing through the entry queue and then a registered output.
// A byte that follows a held carriage return may give two results; the held return
// itself gives none, so the output keeps pace with the input over any stretch.
// Reset is asynchronous, active low, and returns to the start of a line.
// Depends on irclfp_pkg, irclfp_front, irclfp_queue, irclfp_back.
module irc_line_field_parser #(
  parameter int unsigned QueueDepth = irclfp_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] byte_value, [11:8] param_index,
                                        // [12] param_start, [13] command_valid
  output logic [2:0]  m_axis_tuser_o,   // [2:0] byte_kind
  output logic        m_axis_tlast_o
);

  logic               push, pop, full, empty;
  irclfp_pkg::entry_t push_entry, head;
  irclfp_pkg::res_t   res;

  irclfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_byte_i    (s_axis_tdata_i),
    .q_full_i     (full),
    .in_ready_o   (s_axis_tready_o),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  irclfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .full_o       (full),
    .empty_o      (empty),
    .head_o       (head)
  );

  irclfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_res_o   (res)
  );

  assign m_axis_tdata_o = {2'b00, res.cvalid, res.start, res.pidx, res.value};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

endmodule

### hw/rtl/irclfp_front.sv
// Front end: accepts bytes, runs the line phase machine and builds queue entries.
// Depends on irclfp_pkg.
module irclfp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  input  logic                q_full_i,
  output logic                in_ready_o,
  output logic                push_o,
  output irclfp_pkg::entry_t  push_entry_o
);

  typedef struct packed {
    irclfp_pkg::phase_e ph;
    logic [3:0]         cnt;
    logic               seen;
    irclfp_pkg::res_t   res;
  } cls_t;

  function automatic cls_t classify(irclfp_pkg::phase_e ph, logic [3:0] cnt, logic seen,
                                    logic [7:0] b, logic lst);
    cls_t  o;
    logic  opn;
    o.ph   = ph;
    o.cnt  = cnt;
    o.seen = seen;
    o.res.kind   = irclfp_pkg::KIND_SEP;
    o.res.value  = b;
    o.res.start  = 1'b0;
    o.res.cvalid = 1'b0;
    o.res.last   = lst;
    opn = 1'b0;
    case (ph)
      irclfp_pkg::PH_TAGS: begin
        if (b == irclfp_pkg::CHAR_SPACE) o.ph = irclfp_pkg::PH_PFX_OR_CMD;
        else o.res.kind = irclfp_pkg::KIND_TAGS;
      end
      irclfp_pkg::PH_PFX_OR_CMD: begin
        if (b == irclfp_pkg::CHAR_COLON) begin
          o.ph = irclfp_pkg::PH_PREFIX;
        end else begin
          o.ph = irclfp_pkg::PH_CMD;
          o.res.kind = irclfp_pkg::KIND_COMMAND;
        end
      end
      irclfp_pkg::PH_PREFIX: begin
        if (b == irclfp_pkg::CHAR_SPACE) o.ph = irclfp_pkg::PH_CMD_FIRST;
        else o.res.kind = irclfp_pkg::KIND_PREFIX;
      end
      irclfp_pkg::PH_CMD_FIRST: begin
        if (b != irclfp_pkg::CHAR_SPACE) begin
          o.ph = irclfp_pkg::PH_CMD;
          o.res.kind = irclfp_pkg::KIND_COMMAND;
        end
      end
      irclfp_pkg::PH_CMD: begin
        if (b == irclfp_pkg::CHAR_SPACE) o.ph = irclfp_pkg::PH_PARAM_FIRST;
        else o.res.kind = irclfp_pkg::KIND_COMMAND;
      end
      irclfp_pkg::PH_PARAM_FIRST: begin
        if (b == irclfp_pkg::CHAR_COLON) begin
          o.ph = irclfp_pkg::PH_TRAILER;
          opn  = 1'b1;
        end else if (b != irclfp_pkg::CHAR_SPACE) begin
          o.ph = irclfp_pkg::PH_PARAM;
          opn  = 1'b1;
          o.res.kind = irclfp_pkg::KIND_PARAM;
        end
      end
      irclfp_pkg::PH_PARAM: begin
        if (b == irclfp_pkg::CHAR_SPACE) o.ph = irclfp_pkg::PH_PARAM_FIRST;
        else o.res.kind = irclfp_pkg::KIND_PARAM;
      end
      irclfp_pkg::PH_TRAILER: begin
        o.res.kind = irclfp_pkg::KIND_TRAILER;
      end
      default: begin
        if (b == irclfp_pkg::CHAR_AT) begin
          o.ph = irclfp_pkg::PH_TAGS;
        end else if (b == irclfp_pkg::CHAR_COLON) begin
          o.ph = irclfp_pkg::PH_PREFIX;
        end else begin
          o.ph = irclfp_pkg::PH_CMD;
          o.res.kind = irclfp_pkg::KIND_COMMAND;
        end
      end
    endcase
    if (opn) begin
      o.res.start = 1'b1;
      if (seen) begin
        if (cnt < 4'(irclfp_pkg::PCNT_TOP)) o.cnt = cnt + 4'd1;
      end else begin
        o.seen = 1'b1;
        o.cnt  = 4'd0;
      end
    end
    o.res.pidx = o.cnt;
    return o;
  endfunction

  irclfp_pkg::phase_e phase_q, phase_d;
  logic               pend_q, pend_d;
  logic [3:0]         pcnt_q, pcnt_d;
  logic               seen_q, seen_d;

  cls_t               held_cls, byte_cls;
  irclfp_pkg::phase_e mid_ph;
  logic [3:0]         mid_cnt;
  logic               mid_seen;
  logic               accept;
  logic               have_any;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    held_cls = classify(phase_q, pcnt_q, seen_q, irclfp_pkg::CHAR_CR,
                        in_byte_i == irclfp_pkg::CHAR_CR);
    if (pend_q) begin
      mid_ph   = held_cls.ph;
      mid_cnt  = held_cls.cnt;
      mid_seen = held_cls.seen;
    end else begin
      mid_ph   = phase_q;
      mid_cnt  = pcnt_q;
      mid_seen = seen_q;
    end
    byte_cls = classify(mid_ph, mid_cnt, mid_seen, in_byte_i, 1'b1);

    push_entry_o = '0;
    have_any     = 1'b0;
    phase_d = phase_q;
    pend_d  = pend_q;
    pcnt_d  = pcnt_q;
    seen_d  = seen_q;

    if (pend_q && in_byte_i == irclfp_pkg::CHAR_LF) begin
      have_any = 1'b1;
      push_entry_o.r0.kind   = irclfp_pkg::KIND_EOL;
      push_entry_o.r0.value  = 8'd0;
      push_entry_o.r0.pidx   = pcnt_q;
      push_entry_o.r0.start  = 1'b0;
      push_entry_o.r0.cvalid = (phase_q == irclfp_pkg::PH_CMD) ||
                               (phase_q == irclfp_pkg::PH_PARAM_FIRST) ||
                               (phase_q == irclfp_pkg::PH_PARAM) ||
                               (phase_q == irclfp_pkg::PH_TRAILER);
      push_entry_o.r0.last   = 1'b1;
      phase_d = irclfp_pkg::PH_LINE_FIRST;
      pend_d  = 1'b0;
      pcnt_d  = 4'd0;
      seen_d  = 1'b0;
    end else begin
      if (pend_q) begin
        have_any = 1'b1;
        push_entry_o.r0 = held_cls.res;
      end
      phase_d = mid_ph;
      pcnt_d  = mid_cnt;
      seen_d  = mid_seen;
      if (in_byte_i == irclfp_pkg::CHAR_CR) begin
        pend_d = 1'b1;
      end else begin
        pend_d  = 1'b0;
        phase_d = byte_cls.ph;
        pcnt_d  = byte_cls.cnt;
        seen_d  = byte_cls.seen;
        if (pend_q) begin
          push_entry_o.two = 1'b1;
          push_entry_o.r1  = byte_cls.res;
        end else begin
          push_entry_o.r0  = byte_cls.res;
        end
        have_any = 1'b1;
      end
    end
  end

  assign push_o = accept && have_any;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= irclfp_pkg::PH_LINE_FIRST;
      pend_q  <= 1'b0;
      pcnt_q  <= 4'd0;
      seen_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      pcnt_q  <= pcnt_d;
      seen_q  <= seen_d;
    end
  end

endmodule

### hw/rtl/irclfp_queue.sv
// Short entry queue between the front and back ends of the line parser.
// Depends on irclfp_pkg.
module irclfp_queue #(
  parameter int unsigned Depth = irclfp_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  irclfp_pkg::entry_t  push_entry_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output irclfp_pkg::entry_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  irclfp_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    if (do_pop) rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    if (push_i && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!push_i && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

### hw/rtl/irclfp_back.sv
// Back end: splits queue entries into single results and drives the output register.
// Depends on irclfp_pkg.
module irclfp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  irclfp_pkg::entry_t  head_i,
  input  logic                empty_i,
  output logic                pop_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output irclfp_pkg::res_t    out_res_o
);

  logic             valid_q, valid_d;
  logic             sel_q, sel_d;
  irclfp_pkg::res_t res_q;
  irclfp_pkg::res_t pick;
  logic             load;

  assign load  = !empty_i && (!valid_q || out_ready_i);
  assign pick  = sel_q ? head_i.r1 : head_i.r0;
  assign pop_o = load && (sel_q || !head_i.two);

  always_comb begin
    sel_d   = sel_q;
    valid_d = valid_q;
    if (load) begin
      sel_d   = !sel_q && head_i.two;
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= pick;
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

### hw/rtl/irclfp_checker.sv
// Port-level checks for irc_line_field_parser, bound to the top level.
// Depends on irclfp_pkg.
module irclfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("output changed while stalled");

  a_eol_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == 3'(irclfp_pkg::KIND_EOL) |->
      m_axis_tdata_o[7:0] == 8'd0 && !m_axis_tdata_o[12] && m_axis_tlast_o)
    else $error("malformed end of line result");

  a_cvalid_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[13] |->
      m_axis_tuser_o == 3'(irclfp_pkg::KIND_EOL))
    else $error("command_valid outside end of line");

  // a colon that opens the trailer is a dropped separator carrying the start flag
  a_start_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[12] |->
      m_axis_tuser_o == 3'(irclfp_pkg::KIND_PARAM) ||
      m_axis_tuser_o == 3'(irclfp_pkg::KIND_SEP))
    else $error("parameter start on wrong kind");

endmodule

bind irc_line_field_parser irclfp_checker u_irclfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
